// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the go-to-goal controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ===== sv/gtg_pkg.sv =====
// Shared constants, register codes and the arctangent table of the go-to-goal controller.
package gtg_pkg;

   // Default number of CORDIC rotations
   localparam int CORDIC_STEPS_DEF = 16;
   // Result bits of the distance square root (radicand up to 34 bits)
   localparam int SQRT_STEPS = 17;

   // Datapath widths
   localparam int CORDIC_W = 36;   // x, y of the vectoring unit
   localparam int ANGLE_W  = 34;   // angle accumulator, Q30 radians
   localparam int RAD_W    = 34;   // dx*dx + dy*dy
   localparam int ROOT_W   = 17;   // distance, Q9.8
   localparam int REM_W    = 18;   // square root remainder

   // Configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_X   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Y   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED  = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE_THR = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_THR   = 8'd5;

   // Register reset values
   localparam logic signed [15:0] TARGET_X_RST = 16'sd256;
   localparam logic signed [15:0] TARGET_Y_RST = 16'sd256;
   localparam logic [11:0] GAIN_RST       = 12'd256;
   localparam logic [14:0] MAX_SPEED_RST  = 15'd768;
   localparam logic [14:0] ARRIVE_THR_RST = 15'd26;
   localparam logic [14:0] TURN_THR_RST   = 15'd819;

   // pi/2 in Q30
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

   // Truncated atan(2^-i) in Q30
   function automatic logic signed [ANGLE_W-1:0] atan_q30(input int idx);
      logic signed [ANGLE_W-1:0] val;
      case (idx)
         0:  val = 34'sd843314856;
         1:  val = 34'sd497837829;
         2:  val = 34'sd263043836;
         3:  val = 34'sd133525158;
         4:  val = 34'sd67021686;
         5:  val = 34'sd33543515;
         6:  val = 34'sd16775850;
         7:  val = 34'sd8388437;
         8:  val = 34'sd4194282;
         9:  val = 34'sd2097149;
         10: val = 34'sd1048575;
         11: val = 34'sd524287;
         12: val = 34'sd262143;
         13: val = 34'sd131071;
         14: val = 34'sd65535;
         15: val = 34'sd32767;
         16: val = 34'sd16383;
         17: val = 34'sd8191;
         18: val = 34'sd4095;
         19: val = 34'sd2047;
         20: val = 34'sd1023;
         21: val = 34'sd511;
         22: val = 34'sd255;
         23: val = 34'sd127;
         default: val = 34'sd0;
      endcase
      return val;
   endfunction

endpackage

// ===== sv/go_to_goal_controller.sv =====
// Go-to-goal controller top level: offsets, distance and bearing pipelines, speed decision.
// Throughput: one pose per cycle while not stalled; the CORDIC stages and the 17 square root stages run side by side.
// The pipeline stalls as a whole only when the output register waits and the last stage is full.
// Reset (synchronous, active high) clears all valid bits and loads register reset values.
`include "assert_macros.svh"
module go_to_goal_controller #(
   parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] pos_x, [31:16] pos_y, [46:32] heading, [47] zero
   input  logic [47:0]                       req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [14:0] linear_speed, [29:15] angular_speed, [31:30] zero
   output logic [31:0]                       rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gtg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gtg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PIPE_DEPTH = (CORDIC_STEPS > gtg_pkg::SQRT_STEPS + 1) ?
                               CORDIC_STEPS : gtg_pkg::SQRT_STEPS + 1;
   localparam int NST    = PIPE_DEPTH + 4;   // valid stages
   localparam int HD_LEN = PIPE_DEPTH + 2;   // heading delay up to the decision stage

   // Configuration registers
   logic signed [15:0] target_x_ff;
   logic signed [15:0] target_y_ff;
   logic [11:0]        gain_ff;
   logic [14:0]        max_speed_ff;
   logic [14:0]        arrive_thr_ff;
   logic [14:0]        turn_thr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff   <= gtg_pkg::TARGET_X_RST;
         target_y_ff   <= gtg_pkg::TARGET_Y_RST;
         gain_ff       <= gtg_pkg::GAIN_RST;
         max_speed_ff  <= gtg_pkg::MAX_SPEED_RST;
         arrive_thr_ff <= gtg_pkg::ARRIVE_THR_RST;
         turn_thr_ff   <= gtg_pkg::TURN_THR_RST;
      end else if (csr_valid) begin
         case (csr_index)
            gtg_pkg::CSR_TARGET_X:   target_x_ff   <= csr_wdata;
            gtg_pkg::CSR_TARGET_Y:   target_y_ff   <= csr_wdata;
            gtg_pkg::CSR_GAIN:       gain_ff       <= csr_wdata[11:0];
            gtg_pkg::CSR_MAX_SPEED:  max_speed_ff  <= csr_wdata[14:0];
            gtg_pkg::CSR_ARRIVE_THR: arrive_thr_ff <= csr_wdata[14:0];
            gtg_pkg::CSR_TURN_THR:   turn_thr_ff   <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // Pipeline flow control
   logic v_ff [NST];
   logic rsp_valid_ff;
   logic out_load;
   logic en;

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign en         = out_load || !v_ff[NST-1];
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= req_tvalid;
         for (int k = 1; k < NST; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // Heading delay line
   logic signed [14:0] hd_ff [HD_LEN];

   always_ff @(posedge clock) begin
      if (en) begin
         hd_ff[0] <= req_tdata[46:32];
         for (int k = 1; k < HD_LEN; k++) begin
            hd_ff[k] <= hd_ff[k-1];
         end
      end
   end

   // Stage 1: offsets to the target
   logic signed [16:0] pos_x_ext;
   logic signed [16:0] pos_y_ext;
   logic signed [16:0] dx_in;
   logic signed [16:0] dy_in;
   logic signed [16:0] dx_ff;
   logic signed [16:0] dy_ff;

   assign pos_x_ext = {req_tdata[15], req_tdata[15:0]};
   assign pos_y_ext = {req_tdata[31], req_tdata[31:16]};
   assign dx_in     = {target_x_ff[15], target_x_ff} - pos_x_ext;
   assign dy_in     = {target_y_ff[15], target_y_ff} - pos_y_ext;

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   // Stage 2: squares, and pre-rotation into the right half plane
   logic signed [33:0] sqx_full;
   logic signed [33:0] sqy_full;
   logic [31:0]        sqx_ff;
   logic [31:0]        sqy_ff;
   logic signed [gtg_pkg::CORDIC_W-1:0] ex;
   logic signed [gtg_pkg::CORDIC_W-1:0] ey;
   logic signed [gtg_pkg::CORDIC_W-1:0] cx_in;
   logic signed [gtg_pkg::CORDIC_W-1:0] cy_in;
   logic signed [gtg_pkg::ANGLE_W-1:0]  cz_in;
   logic signed [gtg_pkg::CORDIC_W-1:0] cx_ff;
   logic signed [gtg_pkg::CORDIC_W-1:0] cy_ff;
   logic signed [gtg_pkg::ANGLE_W-1:0]  cz_ff;

   assign sqx_full = dx_ff * dx_ff;
   assign sqy_full = dy_ff * dy_ff;
   assign ex = {{(gtg_pkg::CORDIC_W - 33){dx_ff[16]}}, dx_ff, 16'd0};
   assign ey = {{(gtg_pkg::CORDIC_W - 33){dy_ff[16]}}, dy_ff, 16'd0};

   always_comb begin
      cx_in = ex;
      cy_in = ey;
      cz_in = '0;
      if (ex < 0) begin
         if (ey >= 0) begin
            cx_in = ey;
            cy_in = -ex;
            cz_in = gtg_pkg::HALF_PI_Q30;
         end else begin
            cx_in = -ey;
            cy_in = ex;
            cz_in = -gtg_pkg::HALF_PI_Q30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= sqx_full[31:0];
         sqy_ff <= sqy_full[31:0];
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         cz_ff  <= cz_in;
      end
   end

   // Stage 3: squared distance
   logic [gtg_pkg::RAD_W-1:0] rad_in;
   logic [gtg_pkg::RAD_W-1:0] rad_ff;

   assign rad_in = {2'b00, sqx_ff} + {2'b00, sqy_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= rad_in;
      end
   end

   // Distance and bearing units, aligned to finish together
   logic [gtg_pkg::ROOT_W-1:0]         dist_q8;
   logic signed [gtg_pkg::ANGLE_W-1:0] bear_z;

   gtg_isqrt #(
      .DEPTH (PIPE_DEPTH - 1)
   ) u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (rad_ff),
      .root     (dist_q8)
   );

   gtg_cordic #(
      .STEPS (CORDIC_STEPS),
      .DEPTH (PIPE_DEPTH)
   ) u_cordic (
      .clock   (clock),
      .en      (en),
      .vec_x   (cx_ff),
      .vec_y   (cy_ff),
      .ang_z   (cz_ff),
      .ang_out (bear_z)
   );

   // Decision stage A: round the bearing, error magnitude, compares, gain product
   logic signed [gtg_pkg::ANGLE_W:0] z_rnd;
   logic signed [16:0] bear;
   logic signed [17:0] err;
   logic [17:0]        err_neg;
   logic [16:0]        aerr;
   logic               arrived_ff;
   logic               turn_ff;
   logic [14:0]        ang_ff;
   logic [28:0]        prod_ff;

   assign z_rnd   = {bear_z[gtg_pkg::ANGLE_W-1], bear_z} + 35'sd131072;
   assign bear    = z_rnd[gtg_pkg::ANGLE_W -: 17];
   assign err     = {bear[16], bear} - {{3{hd_ff[HD_LEN-1][14]}}, hd_ff[HD_LEN-1]};
   assign err_neg = -err;
   assign aerr    = err[17] ? err_neg[16:0] : err[16:0];

   always_ff @(posedge clock) begin
      if (en) begin
         arrived_ff <= (dist_q8 <= {2'b00, arrive_thr_ff});
         turn_ff    <= (aerr > {2'b00, turn_thr_ff});
         ang_ff     <= aerr[14:0];
         prod_ff    <= {17'd0, gain_ff} * {12'd0, dist_q8};
      end
   end

   // Decision stage B: scale, clamp and select
   logic [20:0] lin_raw;
   logic [14:0] lin_clamp;
   logic [14:0] lin_in;
   logic [14:0] ang_in;
   logic [14:0] lin_ff;
   logic [14:0] ang_sel_ff;

   assign lin_raw   = prod_ff[28:8];
   assign lin_clamp = (lin_raw > {6'd0, max_speed_ff}) ? max_speed_ff : lin_raw[14:0];
   assign lin_in    = (arrived_ff || turn_ff) ? 15'd0 : lin_clamp;
   assign ang_in    = (!arrived_ff && turn_ff) ? ang_ff : 15'd0;

   always_ff @(posedge clock) begin
      if (en) begin
         lin_ff     <= lin_in;
         ang_sel_ff <= ang_in;
      end
   end

   // Output register: load when empty or when the current transfer completes
   logic [14:0] rsp_lin_ff;
   logic [14:0] rsp_ang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= v_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_lin_ff <= lin_ff;
         rsp_ang_ff <= ang_sel_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ang_ff, rsp_lin_ff};

   // Checks
   `ASSERT_IMPLIES(a_full_stall_blocks_input, clock, reset, rsp_valid_ff && !rsp_tready && v_ff[NST-1], !req_tready, "input taken while pipeline is full and stalled")
   `ASSERT_IMPLIES(a_one_speed_only, clock, reset, rsp_valid_ff, rsp_lin_ff == 15'd0 || rsp_ang_ff == 15'd0, "both speeds nonzero")
   `ASSERT_IMPLIES(a_speed_clamped, clock, reset, rsp_valid_ff, rsp_lin_ff <= max_speed_ff, "linear speed above clamp")
   `ASSERT_NEXT(a_accept_enters, clock, reset, req_tvalid && req_tready, v_ff[0], "accepted pose lost at pipeline entry")

endmodule

// ===== sv/gtg_cordic.sv =====
// Pipelined CORDIC vectoring unit: one rotation per stage, padded with delay stages.
module gtg_cordic #(
   parameter int STEPS = gtg_pkg::CORDIC_STEPS_DEF,
   parameter int DEPTH = gtg_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [gtg_pkg::CORDIC_W-1:0]  vec_x,
   input  logic signed [gtg_pkg::CORDIC_W-1:0]  vec_y,
   input  logic signed [gtg_pkg::ANGLE_W-1:0]   ang_z,
   output logic signed [gtg_pkg::ANGLE_W-1:0]   ang_out
);

   logic signed [gtg_pkg::CORDIC_W-1:0] src_x [DEPTH];
   logic signed [gtg_pkg::CORDIC_W-1:0] src_y [DEPTH];
   logic signed [gtg_pkg::ANGLE_W-1:0]  src_z [DEPTH];
   logic signed [gtg_pkg::CORDIC_W-1:0] x_in  [DEPTH];
   logic signed [gtg_pkg::CORDIC_W-1:0] y_in  [DEPTH];
   logic signed [gtg_pkg::ANGLE_W-1:0]  z_in  [DEPTH];
   logic signed [gtg_pkg::CORDIC_W-1:0] x_ff  [DEPTH];
   logic signed [gtg_pkg::CORDIC_W-1:0] y_ff  [DEPTH];
   logic signed [gtg_pkg::ANGLE_W-1:0]  z_ff  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_stage
      // Chain stage inputs
      if (i == 0) begin : g_first
         assign src_x[i] = vec_x;
         assign src_y[i] = vec_y;
         assign src_z[i] = ang_z;
      end else begin : g_next
         assign src_x[i] = x_ff[i-1];
         assign src_y[i] = y_ff[i-1];
         assign src_z[i] = z_ff[i-1];
      end

      if (i < STEPS) begin : g_iter
         localparam logic signed [gtg_pkg::ANGLE_W-1:0] ATAN_I = gtg_pkg::atan_q30(i);
         // Rotate toward the x axis, accumulate the angle
         assign x_in[i] = (src_y[i] > 0) ? src_x[i] + (src_y[i] >>> i)
                                         : src_x[i] - (src_y[i] >>> i);
         assign y_in[i] = (src_y[i] > 0) ? src_y[i] - (src_x[i] >>> i)
                                         : src_y[i] + (src_x[i] >>> i);
         assign z_in[i] = (src_y[i] > 0) ? src_z[i] + ATAN_I : src_z[i] - ATAN_I;
      end else begin : g_pass
         // Delay only, to line up with the distance path
         assign x_in[i] = src_x[i];
         assign y_in[i] = src_y[i];
         assign z_in[i] = src_z[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
      end
   end

   assign ang_out = z_ff[DEPTH-1];

endmodule

// ===== sv/gtg_isqrt.sv =====
// Pipelined integer square root: one result bit per stage, padded with delay stages.
module gtg_isqrt #(
   parameter int DEPTH = gtg_pkg::SQRT_STEPS
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic [gtg_pkg::RAD_W-1:0]         radicand,
   output logic [gtg_pkg::ROOT_W-1:0]        root
);

   localparam int SH_W = gtg_pkg::REM_W + 2;

   logic [gtg_pkg::RAD_W-1:0]  src_rad  [DEPTH];
   logic [gtg_pkg::REM_W-1:0]  src_rem  [DEPTH];
   logic [gtg_pkg::ROOT_W-1:0] src_root [DEPTH];
   logic [SH_W-1:0]            rem_sh   [DEPTH];
   logic [SH_W-1:0]            trial    [DEPTH];
   logic [SH_W-1:0]            diff     [DEPTH];
   logic [gtg_pkg::RAD_W-1:0]  rad_in   [DEPTH];
   logic [gtg_pkg::REM_W-1:0]  rem_in   [DEPTH];
   logic [gtg_pkg::ROOT_W-1:0] root_in  [DEPTH];
   logic [gtg_pkg::RAD_W-1:0]  rad_ff   [DEPTH];
   logic [gtg_pkg::REM_W-1:0]  rem_ff   [DEPTH];
   logic [gtg_pkg::ROOT_W-1:0] root_ff  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_stage
      // Chain stage inputs
      if (i == 0) begin : g_first
         assign src_rad[i]  = radicand;
         assign src_rem[i]  = '0;
         assign src_root[i] = '0;
      end else begin : g_next
         assign src_rad[i]  = rad_ff[i-1];
         assign src_rem[i]  = rem_ff[i-1];
         assign src_root[i] = root_ff[i-1];
      end

      if (i < gtg_pkg::SQRT_STEPS) begin : g_iter
         // Bring down two radicand bits, try the next root bit
         assign rem_sh[i]  = {src_rem[i], src_rad[i][gtg_pkg::RAD_W-1 -: 2]};
         assign trial[i]   = {1'b0, src_root[i], 2'b01};
         assign diff[i]    = rem_sh[i] - trial[i];
         assign rad_in[i]  = {src_rad[i][gtg_pkg::RAD_W-3:0], 2'b00};
         assign rem_in[i]  = (rem_sh[i] >= trial[i]) ? diff[i][gtg_pkg::REM_W-1:0]
                                                     : rem_sh[i][gtg_pkg::REM_W-1:0];
         assign root_in[i] = {src_root[i][gtg_pkg::ROOT_W-2:0], (rem_sh[i] >= trial[i])};
      end else begin : g_pass
         assign rem_sh[i]  = '0;
         assign trial[i]   = '0;
         assign diff[i]    = '0;
         assign rad_in[i]  = src_rad[i];
         assign rem_in[i]  = src_rem[i];
         assign root_in[i] = src_root[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[i]  <= rad_in[i];
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
         end
      end
   end

   assign root = root_ff[DEPTH-1];

endmodule

// ===== sim/go_to_goal_controller_test.sv =====
// Self-checking testbench for the go-to-goal controller: pose stream in, speed commands out.
`timescale 1ns / 1ps

package gtg_check_pkg;

   // Truncated atan(2^-i) in Q30 radians
   localparam longint ATAN_Q30 [24] = '{
      843314856, 497837829, 263043836, 133525158,
      67021686, 33543515, 16775850, 8388437,
      4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767,
      16383, 8191, 4095, 2047,
      1023, 511, 255, 127
   };
   localparam longint HALF_PI_Q30 = 1686629713;
   localparam int     ROTATIONS   = gtg_pkg::CORDIC_STEPS_DEF;

   // One pose and the speed command it must produce
   typedef struct {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [14:0] heading;
      logic [14:0] linear;
      logic [14:0] angular;
   } drive_cmd_type;

   class goal_scoreboard_type;
      logic signed [15:0] tgt_x;
      logic signed [15:0] tgt_y;
      logic [11:0]        gain;
      logic [14:0]        max_spd;
      logic [14:0]        arrive_thr;
      logic [14:0]        turn_thr;
      drive_cmd_type      expected_cmds[$];
      int                 errors;

      function new();
         tgt_x      = gtg_pkg::TARGET_X_RST;
         tgt_y      = gtg_pkg::TARGET_Y_RST;
         gain       = gtg_pkg::GAIN_RST;
         max_spd    = gtg_pkg::MAX_SPEED_RST;
         arrive_thr = gtg_pkg::ARRIVE_THR_RST;
         turn_thr   = gtg_pkg::TURN_THR_RST;
         errors     = 0;
      endfunction

      // Mirror a register write; unknown indexes drop silently
      function void write_reg(logic [gtg_pkg::CSR_IDX_W-1:0] idx, logic [15:0] wdata);
         case (idx)
            gtg_pkg::CSR_TARGET_X:   tgt_x      = wdata;
            gtg_pkg::CSR_TARGET_Y:   tgt_y      = wdata;
            gtg_pkg::CSR_GAIN:       gain       = wdata[11:0];
            gtg_pkg::CSR_MAX_SPEED:  max_spd    = wdata[14:0];
            gtg_pkg::CSR_ARRIVE_THR: arrive_thr = wdata[14:0];
            gtg_pkg::CSR_TURN_THR:   turn_thr   = wdata[14:0];
            default: ;
         endcase
      endfunction

      function longint floor_sqrt(longint v);
         longint root;
         longint trial;
         int     b;
         root = 0;
         for (b = 17; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v) root = trial;
         end
         return root;
      endfunction

      // Bearing of (dx, dy) by CORDIC vectoring, Q3.12 radians
      function longint bearing_q12(longint dx, longint dy);
         longint x, y, z, t, xs, ys;
         int     i;
         x = dx * 65536;
         y = dy * 65536;
         z = 0;
         // rotate into the right half plane first
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x = y;  y = -t; z = HALF_PI_Q30;
            end else begin
               x = -y; y = t;  z = -HALF_PI_Q30;
            end
         end
         for (i = 0; i < ROTATIONS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x += ys; y -= xs; z += ATAN_Q30[i];
            end else begin
               x -= ys; y += xs; z -= ATAN_Q30[i];
            end
         end
         // round half up from Q30 to Q12
         return (z + (longint'(1) << 17)) >>> 18;
      endfunction

      // Work out the command for an accepted pose and queue it
      function void note_pose(logic [47:0] data);
         drive_cmd_type cmd;
         longint px, py, hd, dx, dy, dist_q8, err, lin, ang;
         px = $signed(data[15:0]);
         py = $signed(data[31:16]);
         hd = $signed(data[46:32]);
         dx = tgt_x - px;
         dy = tgt_y - py;
         dist_q8 = floor_sqrt(dx * dx + dy * dy);
         lin = 0;
         ang = 0;
         if (dist_q8 > longint'(arrive_thr)) begin
            err = bearing_q12(dx, dy) - hd;
            if (err < 0) err = -err;
            if (err > longint'(turn_thr)) begin
               ang = err;
            end else begin
               lin = (longint'(gain) * dist_q8) >>> 8;
               if (lin > longint'(max_spd)) lin = max_spd;
            end
         end
         cmd.pos_x   = data[15:0];
         cmd.pos_y   = data[31:16];
         cmd.heading = data[46:32];
         cmd.linear  = lin[14:0];
         cmd.angular = ang[14:0];
         expected_cmds.push_back(cmd);
      endfunction

      task report_mismatch(string msg);
         if (errors < 100) $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Compare a transferred command with the oldest expectation
      task check_command(logic [31:0] data);
         drive_cmd_type cmd;
         if (expected_cmds.size() == 0) begin
            report_mismatch($sformatf("command %h with no pose outstanding", data));
         end else begin
            cmd = expected_cmds.pop_front();
            if (data[14:0] !== cmd.linear)
               report_mismatch($sformatf("pose (%0d,%0d,%0d): linear_speed %0d, expected %0d",
                  $signed(cmd.pos_x), $signed(cmd.pos_y), $signed(cmd.heading),
                  data[14:0], cmd.linear));
            if (data[29:15] !== cmd.angular)
               report_mismatch($sformatf("pose (%0d,%0d,%0d): angular_speed %0d, expected %0d",
                  $signed(cmd.pos_x), $signed(cmd.pos_y), $signed(cmd.heading),
                  data[29:15], cmd.angular));
         end
      endtask

      function int pending();
         return expected_cmds.size();
      endfunction
   endclass

endpackage

module go_to_goal_controller_test;

   localparam int PHASE_ITEMS = 180;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [gtg_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [gtg_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   gtg_check_pkg::goal_scoreboard_type sb = new();
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit long_stall_req = 1'b0;

   go_to_goal_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watch every transfer; check results before noting new poses
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_command(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_pose(req_tdata);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
      end
   end

   // Result side: random back-pressure bursts, and one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_stall_req) begin
            long_stall_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #(2_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [47:0] pack_pose(int px, int py, int hd);
      logic [15:0] x;
      logic [15:0] y;
      logic [14:0] h;
      x = px[15:0];
      y = py[15:0];
      h = hd[14:0];
      return {1'b0, h, y, x};
   endfunction

   // Offer one pose and hold it until the transfer
   task automatic send_pose(logic [47:0] pose);
      req_tdata  <= pose;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic csr_write(logic [gtg_pkg::CSR_IDX_W-1:0] idx, logic [15:0] wdata);
      csr_index <= idx;
      csr_wdata <= wdata;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(logic [15:0] tx, logic [15:0] ty, logic [15:0] g,
                             logic [15:0] ms, logic [15:0] at, logic [15:0] tt);
      csr_write(gtg_pkg::CSR_TARGET_X, tx);
      csr_write(gtg_pkg::CSR_TARGET_Y, ty);
      csr_write(gtg_pkg::CSR_GAIN, g);
      csr_write(gtg_pkg::CSR_MAX_SPEED, ms);
      csr_write(gtg_pkg::CSR_ARRIVE_THR, at);
      csr_write(gtg_pkg::CSR_TURN_THR, tt);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Mostly poses aimed close to the goal bearing, some near the goal, some noise
   function automatic logic [47:0] random_pose();
      int kind, px, py, hd, span;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         px = $urandom;
         py = $urandom;
         hd = $urandom;
      end else if (kind < 4) begin
         px = sb.tgt_x + int'($urandom_range(0, 1200)) - 600;
         py = sb.tgt_y + int'($urandom_range(0, 1200)) - 600;
         hd = int'($urandom_range(0, 25736)) - 12868;
      end else begin
         px = sb.tgt_x + int'($urandom_range(0, 8192)) - 4096;
         py = sb.tgt_y + int'($urandom_range(0, 8192)) - 4096;
         px = $signed(px[15:0]);
         py = $signed(py[15:0]);
         span = (sb.turn_thr > 4032) ? 4096 : int'(sb.turn_thr) + 64;
         hd = int'(sb.bearing_q12(sb.tgt_x - px, sb.tgt_y - py))
              + int'($urandom_range(0, 2 * span)) - span;
      end
      return pack_pose(px, py, hd);
   endfunction

   task automatic run_random(int count);
      repeat (count) begin
         send_pose(random_pose());
         if (req_idle_on && $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   // Directed poses against the reset goal (256, 256)
   task automatic run_directed();
      send_pose(pack_pose(256, 256, 0));             // exactly on target
      send_pose(pack_pose(266, 276, 100));           // inside arrive radius
      send_pose(pack_pose(282, 256, 0));             // distance equals threshold
      send_pose(pack_pose(283, 256, 0));             // just outside threshold
      send_pose(pack_pose(0, 0, 3217));              // drive straight at goal
      send_pose(pack_pose(0, 0, -12868));            // turn in place
      send_pose(pack_pose(0, 256, 819));             // error right at turn limit
      send_pose(pack_pose(0, 256, 820));
      send_pose(pack_pose(0, 256, -819));
      send_pose(pack_pose(1000, 0, 0));              // goal behind, above
      send_pose(pack_pose(1000, 1000, 0));           // goal behind, below
      send_pose(pack_pose(1000, 256, 12868));        // goal straight behind
      send_pose(pack_pose(256, 0, 6434));            // goal straight up
      send_pose(pack_pose(256, 1000, -6434));        // goal straight down
      send_pose(pack_pose(-32768, -32768, 3217));    // far away: speed clamps
      send_pose(pack_pose(32767, 32767, -12868));
      send_pose(pack_pose(32767, -32768, 12868));
      send_pose(pack_pose(-32768, 32767, -16384));   // heading field extremes
      send_pose(pack_pose(-1, -1, 16383));
      send_pose(pack_pose(-32768, 256, 0));          // long drive along x
      req_tvalid <= 1'b0;
   endtask

   initial begin
      int phase;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      for (phase = 0; phase < 8; phase++) begin
         // registers change only with the pipeline empty
         wait_drained();
         case (phase)
            0: ;
            1: begin
               set_config(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
               csr_write(8'd6, 16'h1234);
               csr_write(8'hFF, 16'hFFFF);
            end
            2: set_config(16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'h7FFF, 16'd25736);
            3: set_config(16'd0, 16'd0, 16'd1, 16'd100, 16'd1, 16'hFFFF);
            default: set_config(16'($urandom), 16'($urandom), 16'($urandom_range(0, 4095)),
                                16'($urandom_range(0, 32767)), 16'($urandom_range(0, 1024)),
                                16'($urandom_range(0, 25736)));
         endcase
         req_idle_on = !(phase == 3 || phase >= 5);
         rsp_idle_on = !(phase == 3 || phase == 7);
         // fill the pipeline against a stalled receiver
         if (phase == 5) long_stall_req = 1'b1;
         run_random(PHASE_ITEMS);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
